// ===== rtl/cmac_pkg.sv =====
package cmac_pkg;

    localparam logic [31:0] QNAN_BITS = 32'h7fc00000;

    // Register stages in one floating-point adder.
    localparam int ADD_LAT = 8;

    // Codes of the action field.
    typedef enum logic [1:0] {
        ACT_MUL = 2'd0,
        ACT_ADD = 2'd1,
        ACT_SUB = 2'd2,
        ACT_ALT = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_FIN  = 2'd1,
        KIND_INF  = 2'd2,
        KIND_NAN  = 2'd3
    } kind_t;

    // Unpacked operand: value = (-1)^sgn * man * 2^exp when kind is KIND_FIN.
    typedef struct packed {
        kind_t              kind;
        logic               sgn;
        logic [47:0]        man;
        logic signed [9:0]  exp;
    } unum_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] a_re;
        logic [31:0] a_im;
        logic [31:0] b_re;
        logic [31:0] b_im;
        logic [31:0] p_re;
        logic [31:0] p_im;
        logic        last_in;
    } cmac_in_t;

    typedef struct packed {
        logic [31:0] c_re;
        logic [31:0] c_im;
        logic        last_out;
    } cmac_out_t;

    function automatic unum_t unpack(input logic [31:0] bits);
        unum_t r;
        logic [7:0]  ex;
        logic [22:0] fr;
        ex = bits[30:23];
        fr = bits[22:0];
        r.sgn = bits[31];
        r.man = '0;
        r.exp = '0;
        if (ex == 8'hff) begin
            r.kind = (fr != 23'd0) ? KIND_NAN : KIND_INF;
        end else if (ex == 8'd0) begin
            if (fr == 23'd0) begin
                r.kind = KIND_ZERO;
            end else begin
                r.kind = KIND_FIN;
                r.man  = {25'd0, fr};
                r.exp  = -10'sd149;
            end
        end else begin
            r.kind = KIND_FIN;
            r.man  = {24'd0, 1'b1, fr};
            r.exp  = $signed({2'b00, ex}) - 10'sd150;
        end
        return r;
    endfunction

    function automatic unum_t negate(input unum_t u);
        unum_t r;
        r = u;
        r.sgn = ~u.sgn;
        return r;
    endfunction

    // Zero carrying the sign of u: adding it leaves u (and a zero u) unchanged.
    function automatic unum_t zero_like(input unum_t u);
        unum_t r;
        r.kind = KIND_ZERO;
        r.sgn  = u.sgn;
        r.man  = '0;
        r.exp  = '0;
        return r;
    endfunction

endpackage

// ===== rtl/cmac_fadd.sv =====
module cmac_fadd import cmac_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  unum_t       x,
    input  unum_t       y,
    output logic [31:0] z
);

    localparam logic signed [11:0] ZERO_EXP = -12'sd600;

    typedef struct packed {
        logic        spec;
        logic [31:0] bits;
    } spec_t;

    typedef struct packed {
        spec_t              sp;
        logic               sx;
        logic               sy;
        logic [47:0]        mx;
        logic [47:0]        my;
        logic signed [11:0] ex;
        logic signed [11:0] ey;
    } f1_t;

    typedef struct packed {
        spec_t              sp;
        logic               sgn;
        logic               sub;
        logic [47:0]        mb;
        logic [47:0]        ms;
        logic signed [11:0] eb;
        logic               far;
        logic [5:0]         d;
    } f2_t;

    typedef struct packed {
        spec_t              sp;
        logic               sgn;
        logic               sub;
        logic [63:0]        xw;
        logic [63:0]        ya;
        logic signed [11:0] eb;
    } f3_t;

    typedef struct packed {
        spec_t              sp;
        logic               sgn;
        logic [63:0]        r;
        logic signed [11:0] re;
    } f4_t;

    typedef struct packed {
        spec_t              sp;
        logic               sgn;
        logic               zero;
        logic [63:0]        r;
        logic [5:0]         lz;
        logic signed [11:0] be;
    } f5_t;

    typedef struct packed {
        spec_t              sp;
        logic               sgn;
        logic               zero;
        logic [63:0]        mn;
        logic [5:0]         rs;
        logic signed [11:0] be;
    } f6_t;

    typedef struct packed {
        spec_t              sp;
        logic               sgn;
        logic               zero;
        logic [23:0]        mant;
        logic               g;
        logic               st;
        logic signed [11:0] be;
    } f7_t;

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        n = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) n = 6'(47 - i);
        end
        return n;
    endfunction

    function automatic logic [6:0] lzc64(input logic [63:0] v);
        logic [6:0] n;
        n = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) n = 7'(63 - i);
        end
        return n;
    endfunction

    f1_t f1_next, f1_reg;
    f2_t f2_next, f2_reg;
    f3_t f3_next, f3_reg;
    f4_t f4_next, f4_reg;
    f5_t f5_next, f5_reg;
    f6_t f6_next, f6_reg;
    f7_t f7_next, f7_reg;
    logic [31:0] z_next, z_reg;

    // Stage 1: resolve special operands, normalize both significands to bit 47.
    always_comb begin
        logic [5:0] lzx, lzy;
        lzx = lzc48(x.man);
        lzy = lzc48(y.man);
        f1_next.sp.spec = 1'b0;
        f1_next.sp.bits = '0;
        if (x.kind == KIND_NAN || y.kind == KIND_NAN ||
            (x.kind == KIND_INF && y.kind == KIND_INF && x.sgn != y.sgn)) begin
            f1_next.sp = '{spec: 1'b1, bits: QNAN_BITS};
        end else if (x.kind == KIND_INF) begin
            f1_next.sp = '{spec: 1'b1, bits: {x.sgn, 8'hff, 23'd0}};
        end else if (y.kind == KIND_INF) begin
            f1_next.sp = '{spec: 1'b1, bits: {y.sgn, 8'hff, 23'd0}};
        end else if (x.kind == KIND_ZERO && y.kind == KIND_ZERO) begin
            f1_next.sp = '{spec: 1'b1, bits: {x.sgn & y.sgn, 31'd0}};
        end
        f1_next.sx = x.sgn;
        f1_next.sy = y.sgn;
        if (x.kind == KIND_FIN) begin
            f1_next.mx = x.man << lzx;
            f1_next.ex = 12'(x.exp) - $signed({6'd0, lzx});
        end else begin
            f1_next.mx = '0;
            f1_next.ex = ZERO_EXP;
        end
        if (y.kind == KIND_FIN) begin
            f1_next.my = y.man << lzy;
            f1_next.ey = 12'(y.exp) - $signed({6'd0, lzy});
        end else begin
            f1_next.my = '0;
            f1_next.ey = ZERO_EXP;
        end
    end

    // Stage 2: order by magnitude, exponent distance.
    always_comb begin
        logic               swap;
        logic signed [11:0] ediff;
        swap = (f1_reg.ey > f1_reg.ex) || (f1_reg.ey == f1_reg.ex && f1_reg.my > f1_reg.mx);
        f2_next.sp  = f1_reg.sp;
        f2_next.sub = f1_reg.sx ^ f1_reg.sy;
        if (swap) begin
            f2_next.sgn = f1_reg.sy;
            f2_next.mb  = f1_reg.my;
            f2_next.ms  = f1_reg.mx;
            f2_next.eb  = f1_reg.ey;
            ediff       = f1_reg.ey - f1_reg.ex;
        end else begin
            f2_next.sgn = f1_reg.sx;
            f2_next.mb  = f1_reg.mx;
            f2_next.ms  = f1_reg.my;
            f2_next.eb  = f1_reg.ex;
            ediff       = f1_reg.ex - f1_reg.ey;
        end
        f2_next.far = ediff > 12'sd63;
        f2_next.d   = ediff[5:0];
    end

    // Stage 3: align the smaller operand, fold shifted-out bits into a sticky bit.
    always_comb begin
        logic [63:0] yw, mask;
        logic        stk;
        yw   = {2'b00, f2_reg.ms, 14'd0};
        mask = (64'd1 << f2_reg.d) - 64'd1;
        stk  = |(yw & mask);
        f3_next.sp  = f2_reg.sp;
        f3_next.sgn = f2_reg.sgn;
        f3_next.sub = f2_reg.sub;
        f3_next.xw  = {2'b00, f2_reg.mb, 14'd0};
        f3_next.eb  = f2_reg.eb;
        if (f2_reg.far) begin
            f3_next.ya = {63'd0, |f2_reg.ms};
        end else begin
            f3_next.ya = (yw >> f2_reg.d) | {63'd0, stk};
        end
    end

    // Stage 4: add or subtract magnitudes.
    always_comb begin
        f4_next.sp  = f3_reg.sp;
        f4_next.sgn = f3_reg.sgn;
        f4_next.r   = f3_reg.sub ? (f3_reg.xw - f3_reg.ya) : (f3_reg.xw + f3_reg.ya);
        f4_next.re  = f3_reg.eb - 12'sd14;
    end

    // Stage 5: leading-zero count and biased exponent.
    always_comb begin
        logic [6:0] lz;
        lz = lzc64(f4_reg.r);
        f5_next.sp   = f4_reg.sp;
        f5_next.sgn  = f4_reg.sgn;
        f5_next.zero = (f4_reg.r == 64'd0);
        f5_next.r    = f4_reg.r;
        f5_next.lz   = lz[5:0];
        f5_next.be   = f4_reg.re + 12'sd190 - $signed({5'd0, lz});
    end

    // Stage 6: normalize; compute denormal right shift.
    always_comb begin
        logic signed [11:0] dif;
        dif = 12'sd1 - f5_reg.be;
        f6_next.sp   = f5_reg.sp;
        f6_next.sgn  = f5_reg.sgn;
        f6_next.zero = f5_reg.zero;
        f6_next.mn   = f5_reg.r << f5_reg.lz;
        f6_next.be   = f5_reg.be;
        if (f5_reg.be > 12'sd0) begin
            f6_next.rs = 6'd0;
        end else if (dif > 12'sd63) begin
            f6_next.rs = 6'd63;
        end else begin
            f6_next.rs = dif[5:0];
        end
    end

    // Stage 7: denormal shift, guard and sticky.
    always_comb begin
        logic [63:0] sh, mask;
        logic        stk;
        sh   = f6_reg.mn >> f6_reg.rs;
        mask = (64'd1 << f6_reg.rs) - 64'd1;
        stk  = |(f6_reg.mn & mask);
        f7_next.sp   = f6_reg.sp;
        f7_next.sgn  = f6_reg.sgn;
        f7_next.zero = f6_reg.zero;
        f7_next.mant = sh[63:40];
        f7_next.g    = sh[39];
        f7_next.st   = (|sh[38:0]) | stk;
        f7_next.be   = f6_reg.be;
    end

    // Stage 8: round to nearest even and pack.
    always_comb begin
        logic               inc;
        logic [24:0]        sum;
        logic signed [11:0] bexp;
        inc  = f7_reg.g & (f7_reg.st | f7_reg.mant[0]);
        sum  = {1'b0, f7_reg.mant} + {24'd0, inc};
        bexp = f7_reg.be + $signed({11'd0, sum[24]});
        if (f7_reg.sp.spec) begin
            z_next = f7_reg.sp.bits;
        end else if (f7_reg.zero) begin
            z_next = 32'd0;
        end else if (f7_reg.be > 12'sd0) begin
            if (bexp >= 12'sd255) begin
                z_next = {f7_reg.sgn, 8'hff, 23'd0};
            end else begin
                z_next = {f7_reg.sgn, bexp[7:0], sum[24] ? 23'd0 : sum[22:0]};
            end
        end else begin
            z_next = {f7_reg.sgn, 7'd0, sum[23], sum[22:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_reg <= f1_next;
            f2_reg <= f2_next;
            f3_reg <= f3_next;
            f4_reg <= f4_next;
            f5_reg <= f5_next;
            f6_reg <= f6_next;
            f7_reg <= f7_next;
            z_reg  <= z_next;
        end
    end

    assign z = z_reg;

endmodule

// ===== rtl/complex_fp32_multiply_accumulate.sv =====
// An accepted request passes the multiplier stage, then three chained eight-stage
// floating-point adders, then the output queue to m_valid; a stall holds it in place.
// Throughput: one request per cycle while the output queue has room; every stage is registered.
// A two-entry output queue holds finished results while m_ready is low.
// Reset: aresetn is synchronous, active low; clears valid bits and the queue.
module complex_fp32_multiply_accumulate import cmac_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  cmac_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output cmac_out_t m_data
);

    localparam int DEPTH = 3 * ADD_LAT;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] p_re;
        logic [31:0] p_im;
        logic        last;
    } misc_t;

    typedef struct packed {
        unum_t ii;
        unum_t ir;
    } prod2_t;

    // Exact product: significand up to 48 bits, no rounding.
    function automatic unum_t mul_exact(input unum_t a, input unum_t b);
        unum_t r;
        r.sgn = a.sgn ^ b.sgn;
        r.man = '0;
        r.exp = '0;
        if (a.kind == KIND_NAN || b.kind == KIND_NAN ||
            (a.kind == KIND_INF && b.kind == KIND_ZERO) ||
            (a.kind == KIND_ZERO && b.kind == KIND_INF)) begin
            r.kind = KIND_NAN;
        end else if (a.kind == KIND_INF || b.kind == KIND_INF) begin
            r.kind = KIND_INF;
        end else if (a.kind == KIND_ZERO || b.kind == KIND_ZERO) begin
            r.kind = KIND_ZERO;
        end else begin
            r.kind = KIND_FIN;
            r.man  = a.man[23:0] * b.man[23:0];
            r.exp  = a.exp + b.exp;
        end
        return r;
    endfunction

    logic en;

    // Valid bits: index 0 is the multiplier stage, DEPTH the final adder output.
    logic [DEPTH:0] valid_reg;
    misc_t          misc_reg  [DEPTH+1];
    prod2_t         prod2_reg [ADD_LAT+1];
    unum_t          rr_reg, ri_reg;

    logic [31:0] first_re, first_im, t_re, t_im, c_re, c_im;
    unum_t       x3_re, y3_re, x3_im, y3_im, u_tre, u_tim;

    cmac_out_t fifo_reg [2];
    logic      wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic      push, pop;

    // Advance the whole pipeline whenever the output queue has room.
    assign en      = (cnt_reg != 2'd2);
    assign s_ready = en;

    // Multiplier stage: unpack operands, form the four exact partial products.
    always_ff @(posedge aclk) begin
        if (en) begin
            unum_t ar, ai, br, bi;
            ar = unpack(s_data.a_re);
            ai = unpack(s_data.a_im);
            br = unpack(s_data.b_re);
            bi = unpack(s_data.b_im);
            rr_reg          <= mul_exact(ar, br);
            ri_reg          <= mul_exact(ar, bi);
            prod2_reg[0].ii <= mul_exact(ai, bi);
            prod2_reg[0].ir <= mul_exact(ai, br);
            misc_reg[0]     <= '{action: s_data.action, p_re: s_data.p_re,
                                 p_im: s_data.p_im, last: s_data.last_in};
            for (int i = 1; i <= ADD_LAT; i++) begin
                prod2_reg[i] <= prod2_reg[i-1];
            end
            for (int i = 1; i <= DEPTH; i++) begin
                misc_reg[i] <= misc_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[DEPTH-1:0], s_valid};
        end
    end

    // First rounding: round(ar*br) and round(ar*bi), adding a matching zero.
    cmac_fadd u_round_re (.aclk(aclk), .en(en), .x(rr_reg), .y(zero_like(rr_reg)),
                          .z(first_re));
    cmac_fadd u_round_im (.aclk(aclk), .en(en), .x(ri_reg), .y(zero_like(ri_reg)),
                          .z(first_im));

    // Fused cross terms: rounded first product minus (real) or plus (imaginary) the exact second product.
    cmac_fadd u_cross_re (.aclk(aclk), .en(en), .x(unpack(first_re)),
                          .y(negate(prod2_reg[ADD_LAT].ii)), .z(t_re));
    cmac_fadd u_cross_im (.aclk(aclk), .en(en), .x(unpack(first_im)),
                          .y(prod2_reg[ADD_LAT].ir), .z(t_im));

    // Accumulate: p plus or minus the product; plain multiply and ACT_ALT pass t through.
    always_comb begin
        u_tre = unpack(t_re);
        u_tim = unpack(t_im);
        unique case (misc_reg[2*ADD_LAT].action)
            ACT_ADD: begin
                x3_re = unpack(misc_reg[2*ADD_LAT].p_re);
                x3_im = unpack(misc_reg[2*ADD_LAT].p_im);
                y3_re = u_tre;
                y3_im = u_tim;
            end
            ACT_SUB: begin
                x3_re = unpack(misc_reg[2*ADD_LAT].p_re);
                x3_im = unpack(misc_reg[2*ADD_LAT].p_im);
                y3_re = negate(u_tre);
                y3_im = negate(u_tim);
            end
            default: begin
                x3_re = u_tre;
                x3_im = u_tim;
                y3_re = zero_like(u_tre);
                y3_im = zero_like(u_tim);
            end
        endcase
    end

    cmac_fadd u_acc_re (.aclk(aclk), .en(en), .x(x3_re), .y(y3_re), .z(c_re));
    cmac_fadd u_acc_im (.aclk(aclk), .en(en), .x(x3_im), .y(y3_im), .z(c_im));

    // Output queue: two entries, so a new request still enters while one waits.
    assign push    = en && valid_reg[DEPTH];
    assign m_valid = (cnt_reg != 2'd0);
    assign pop     = m_valid && m_ready;
    assign m_data  = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= '{c_re: c_re, c_im: c_im,
                                     last_out: misc_reg[DEPTH].last};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // Queue never overflows or goes past two entries.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("output queue count out of range");

    // A stalled pipeline holds its valid bits.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(valid_reg)) else $error("valid bits moved during stall");

    // An accepted request shows up in the multiplier stage.
    a_accept_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> valid_reg[0]) else $error("accepted request lost");

    // Any NaN delivered is the canonical quiet NaN.
    a_qnan_re: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.c_re[30:23] == 8'hff && m_data.c_re[22:0] != 23'd0
        |-> m_data.c_re == QNAN_BITS) else $error("non-canonical NaN on c_re");

    a_qnan_im: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.c_im[30:23] == 8'hff && m_data.c_im[22:0] != 23'd0
        |-> m_data.c_im == QNAN_BITS) else $error("non-canonical NaN on c_im");

endmodule

// ===== bench/complex_fp32_multiply_accumulate_test.sv =====
module complex_fp32_multiply_accumulate_test;
    import cmac_pkg::*;

    localparam int RANDOM_REQUESTS = 1030;
    localparam int DRAIN_CYCLES    = 60;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    cmac_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    cmac_out_t m_data;

    complex_fp32_multiply_accumulate u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Exact intermediate value: kind, sign, magnitude man * 2^ex.
    typedef struct {
        kind_t        kind;
        logic         sgn;
        logic [63:0]  man;
        int           ex;
    } wide_t;

    cmac_out_t pending_results[$];
    int        mismatch_count;
    int        result_count;
    bit        idle_free;
    bit        stim_done;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic wide_t widen(input logic [31:0] bits);
        wide_t r;
        r.sgn = bits[31];
        r.man = '0;
        r.ex  = 0;
        if (bits[30:23] == 8'hff) begin
            r.kind = (bits[22:0] != 0) ? KIND_NAN : KIND_INF;
        end else if (bits[30:23] == 8'd0) begin
            r.kind = (bits[22:0] == 0) ? KIND_ZERO : KIND_FIN;
            r.man  = {41'd0, bits[22:0]};
            r.ex   = -149;
        end else begin
            r.kind = KIND_FIN;
            r.man  = {40'd0, 1'b1, bits[22:0]};
            r.ex   = int'(bits[30:23]) - 150;
        end
        return r;
    endfunction

    function automatic wide_t exact_product(input wide_t x, input wide_t y);
        wide_t r;
        r.sgn = x.sgn ^ y.sgn;
        r.man = '0;
        r.ex  = 0;
        if (x.kind == KIND_NAN || y.kind == KIND_NAN
                || (x.kind == KIND_INF && y.kind == KIND_ZERO)
                || (x.kind == KIND_ZERO && y.kind == KIND_INF))
            r.kind = KIND_NAN;
        else if (x.kind == KIND_INF || y.kind == KIND_INF)
            r.kind = KIND_INF;
        else if (x.kind == KIND_ZERO || y.kind == KIND_ZERO)
            r.kind = KIND_ZERO;
        else begin
            r.kind = KIND_FIN;
            r.man  = x.man * y.man;
            r.ex   = x.ex + y.ex;
        end
        return r;
    endfunction

    // Sum, exact up to a sticky bit in bit 0.
    function automatic wide_t exact_sum(input wide_t x, input wide_t y);
        wide_t r;
        wide_t t;
        int    d;
        logic [63:0] ym;
        r.man = '0;
        r.ex  = 0;
        r.sgn = 1'b0;
        r.kind = KIND_NAN;
        if (x.kind == KIND_NAN || y.kind == KIND_NAN
                || (x.kind == KIND_INF && y.kind == KIND_INF && x.sgn != y.sgn))
            return r;
        if (x.kind == KIND_INF) return x;
        if (y.kind == KIND_INF) return y;
        if (x.kind == KIND_ZERO && y.kind == KIND_ZERO) begin
            r.kind = KIND_ZERO;
            r.sgn  = x.sgn & y.sgn;
            return r;
        end
        if (x.kind == KIND_ZERO) return y;
        if (y.kind == KIND_ZERO) return x;
        while (!x.man[61]) begin x.man <<= 1; x.ex--; end
        while (!y.man[61]) begin y.man <<= 1; y.ex--; end
        if (y.ex > x.ex || (y.ex == x.ex && y.man > x.man)) begin
            t = x; x = y; y = t;
        end
        d = x.ex - y.ex;
        if (d >= 63)
            ym = 64'd1;
        else
            ym = (y.man >> d) | {63'd0, ((y.man & ((64'd1 << d) - 64'd1)) != 64'd0)};
        r.ex  = x.ex;
        r.sgn = x.sgn;
        r.man = (x.sgn == y.sgn) ? x.man + ym : x.man - ym;
        r.kind = (r.man == 0) ? KIND_ZERO : KIND_FIN;
        if (r.man == 0) r.sgn = 1'b0;
        return r;
    endfunction

    function automatic logic [31:0] round_even(input wide_t x);
        int p;
        int shift;
        int ef;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        if (x.kind == KIND_NAN) return QNAN_BITS;
        if (x.kind == KIND_INF) return {x.sgn, 8'hff, 23'd0};
        if (x.kind == KIND_ZERO) return {x.sgn, 31'd0};
        p = 63;
        while (p > 0 && !x.man[p]) p--;
        shift = p - 23;
        if (x.ex + shift < -149) shift = -149 - x.ex;
        if (shift <= 0)
            q = x.man << (-shift);
        else if (shift >= 64)
            q = '0;
        else begin
            rem  = x.man & ((64'd1 << shift) - 64'd1);
            half = 64'd1 << (shift - 1);
            q    = x.man >> shift;
            if (rem > half || (rem == half && q[0])) q++;
        end
        ef = x.ex + shift;
        if (q == (64'd1 << 24)) begin q >>= 1; ef++; end
        if (q >= (64'd1 << 23)) begin
            if (ef + 150 >= 255) return {x.sgn, 8'hff, 23'd0};
            return {x.sgn, 8'(ef + 150), q[22:0]};
        end
        return {x.sgn, 8'd0, q[22:0]};
    endfunction

    // round(u*v) +/- w*z with one final rounding.
    function automatic logic [31:0] fused_cross(input logic [31:0] u, v, w, z,
                                                input bit minus);
        wide_t first;
        wide_t second;
        first  = widen(round_even(exact_product(widen(u), widen(v))));
        second = exact_product(widen(w), widen(z));
        if (minus) second.sgn = ~second.sgn;
        return round_even(exact_sum(first, second));
    endfunction

    function automatic cmac_out_t cmac_result(input cmac_in_t req);
        cmac_out_t r;
        wide_t     tr;
        wide_t     ti;
        logic [31:0] pr;
        logic [31:0] pi;
        pr = fused_cross(req.a_re, req.b_re, req.a_im, req.b_im, 1'b1);
        pi = fused_cross(req.a_re, req.b_im, req.a_im, req.b_re, 1'b0);
        r.c_re = pr;
        r.c_im = pi;
        r.last_out = req.last_in;
        if (req.action == ACT_ADD || req.action == ACT_SUB) begin
            tr = widen(pr);
            ti = widen(pi);
            if (req.action == ACT_SUB) begin
                tr.sgn = ~tr.sgn;
                ti.sgn = ~ti.sgn;
            end
            r.c_re = round_even(exact_sum(widen(req.p_re), tr));
            r.c_im = round_even(exact_sum(widen(req.p_im), ti));
        end
        return r;
    endfunction

    // Pick an operand that is often a special or edge value.
    function automatic logic [31:0] rand_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 15))
            0: v = {v[31], 31'd0};
            1: v = {v[31], 8'hff, 23'd0};
            2: v = {v[31], 8'hff, v[22:0] | 23'd1};
            3: v[30:23] = 8'd0;
            4: v[30:23] = 8'(150 - 100 + $urandom_range(0, 30));
            5: v[30:23] = 8'(200 + $urandom_range(0, 54));
            6: v[30:23] = 8'(127 + $urandom_range(0, 6) - 3);
            default: ;
        endcase
        return v;
    endfunction

    function automatic bit take_gap();
        return !idle_free && ($urandom_range(0, 99) < 14);
    endfunction

    // Directed rows; expected value is filled in only where it is obvious.
    typedef struct {
        cmac_in_t  req;
        bit        known;
        cmac_out_t want;
    } row_t;

    row_t directed_rows[$];

    task automatic add_row(input action_t act, input logic [31:0] ar, ai, br, bi,
                           pr, pim, input logic last, input bit known,
                           input logic [31:0] wr, wi);
        row_t r;
        r.req   = '{act, ar, ai, br, bi, pr, pim, last};
        r.known = known;
        r.want  = '{wr, wi, last};
        directed_rows.push_back(r);
    endtask

    // Hold the request until it is accepted; drop valid only while idling.
    task automatic send_request(input cmac_in_t req);
        while (take_gap()) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Result checking at the rising edge.
    always @(posedge aclk) begin
        cmac_out_t want;
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h %h %b",
                             m_data.c_re, m_data.c_im, m_data.last_out);
            end else begin
                want = pending_results.pop_front();
                if (m_data !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: want %h %h %b got %h %h %b",
                                 want.c_re, want.c_im, want.last_out,
                                 m_data.c_re, m_data.c_im, m_data.last_out);
                end
            end
        end
    end

    // Stall the result channel at random.
    always @(negedge aclk) begin
        m_ready <= stim_done || !take_gap();
    end

    // Drive all requests; the long idle-free stretch covers random requests 400 to 649.
    initial begin
        cmac_in_t req;
        int       i;
        int       drain;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;
        mismatch_count = 0;
        result_count   = 0;
        idle_free = 1'b0;
        stim_done = 1'b0;

        // Extremes, every action, NaN, inf*0, inf-inf, exact cancellation, overflow.
        add_row(ACT_MUL, 0, 0, 0, 0, 32'hdeadbeef, 1, 1'b0, 1'b1, 0, 0);
        add_row(ACT_MUL, 32'h3f800000, 0, 32'h3f800000, 0, 0, 0, 1'b1, 1'b1,
                32'h3f800000, 0);
        add_row(ACT_MUL, 32'h7f800000, 0, 0, 0, 0, 0, 1'b0, 1'b1, QNAN_BITS, QNAN_BITS);
        add_row(ACT_MUL, 32'h7fc00001, 0, 32'h3f800000, 0, 0, 0, 1'b1, 1'b1,
                QNAN_BITS, QNAN_BITS);
        add_row(ACT_ADD, 0, 0, 0, 0, 32'h80000000, 32'h80000000, 1'b0, 1'b1, 0, 0);
        add_row(ACT_SUB, 0, 0, 0, 0, 32'h80000000, 32'h80000000, 1'b1, 1'b1,
                32'h80000000, 32'h80000000);
        add_row(ACT_ADD, 32'h3f800000, 0, 32'h3f800000, 0, 32'hbf800000, 0, 1'b0, 1'b1,
                0, 0);
        add_row(ACT_ADD, 32'h7f800000, 0, 32'h3f800000, 0, 32'hff800000, 0, 1'b0, 1'b1,
                QNAN_BITS, QNAN_BITS);
        add_row(ACT_MUL, 32'h7f7fffff, 0, 32'h7f7fffff, 0, 0, 0, 1'b0, 1'b1,
                32'h7f800000, 0);
        add_row(ACT_ALT, 32'h3f800000, 0, 32'h40000000, 0, 32'h7f800000, 0, 1'b1, 1'b1,
                32'h40000000, 0);
        add_row(ACT_MUL, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                32'hffffffff, 32'hffffffff, 1'b1, 1'b0, 0, 0);
        add_row(ACT_MUL, 32'h00000001, 32'h00000001, 32'h3f000000, 32'h3f000000,
                0, 0, 1'b0, 1'b0, 0, 0);
        add_row(ACT_SUB, 32'h7f7fffff, 32'h7f7fffff, 32'hbf800000, 32'h3f800000,
                32'h7f7fffff, 32'hff7fffff, 1'b0, 1'b0, 0, 0);
        add_row(ACT_ADD, 32'h00800000, 32'h80800000, 32'h00800000, 32'h00800000,
                32'h007fffff, 32'h807fffff, 1'b1, 1'b0, 0, 0);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[k]) begin
            req = directed_rows[k].req;
            if (directed_rows[k].known) pending_results.push_back(directed_rows[k].want);
            else pending_results.push_back(cmac_result(req));
            send_request(req);
        end

        for (i = 0; i < RANDOM_REQUESTS; i++) begin
            idle_free = (i >= 400 && i < 650);
            req.action  = 2'($urandom_range(0, 3));
            req.a_re    = rand_operand();
            req.a_im    = rand_operand();
            req.b_re    = rand_operand();
            req.b_im    = rand_operand();
            req.p_re    = rand_operand();
            req.p_im    = rand_operand();
            req.last_in = ($urandom_range(0, 7) == 0);
            pending_results.push_back(cmac_result(req));
            send_request(req);
        end
        s_valid <= 1'b0;
        idle_free = 1'b0;
        stim_done = 1'b1;

        // Drain the pipeline, then let it settle.
        drain = 0;
        while (pending_results.size() != 0 && drain < 5000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d requests (directed and random, all actions) and %0d results",
                 directed_rows.size() + RANDOM_REQUESTS, result_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results still missing",
                     mismatch_count, pending_results.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== complex_fp32_multiply_accumulate.f =====
rtl/cmac_pkg.sv
rtl/cmac_fadd.sv
rtl/complex_fp32_multiply_accumulate.sv
bench/complex_fp32_multiply_accumulate_test.sv
